[src/epr_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// epr_pkg: shared types and constants
// Payload words, CORDIC constants and the arctangent table.
// ---------------------------------------------------------------------------
package epr_pkg;

	localparam int CoordW = 32;
	localparam int TrigW = 34;
	localparam int ZW = 34;
	localparam logic [47:0] TurnPerRad = 48'h28BE60DB9391;
	localparam logic [47:0] TurnPerDeg = 48'd781874935307;
	localparam logic [31:0] HalfPiQ30 = 32'd1686629713;
	localparam logic [TrigW-1:0] InvGainQ30 = TrigW'(652032874);
	localparam int AddrCfgDeg = 0;

	typedef struct packed {
		logic signed [CoordW-1:0] point_x;
		logic signed [CoordW-1:0] point_y;
		logic signed [CoordW-1:0] point_z;
		logic signed [CoordW-1:0] angle_about_x;
		logic signed [CoordW-1:0] angle_about_y;
		logic signed [CoordW-1:0] angle_about_z;
	} in_word_t;

	typedef struct packed {
		logic signed [CoordW-1:0] rotated_x;
		logic signed [CoordW-1:0] rotated_y;
		logic signed [CoordW-1:0] rotated_z;
	} out_word_t;

	function automatic logic signed [ZW-1:0] atan_step(input int i);
		logic signed [ZW-1:0] r;
		begin
			case (i)
				0: r = ZW'(843314857);
				1: r = ZW'(497837829);
				2: r = ZW'(263043837);
				3: r = ZW'(133525159);
				4: r = ZW'(67021687);
				5: r = ZW'(33543516);
				6: r = ZW'(16775851);
				7: r = ZW'(8388437);
				8: r = ZW'(4194283);
				9: r = ZW'(2097149);
				default: r = (i <= 30) ? (ZW'(1) <<< (30 - i)) : '0;
			endcase
			return r;
		end
	endfunction

endpackage

[src/epr_cordic_cell.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// epr_cordic_cell: one CORDIC micro-rotation
// Rotates three (x, y, z) triples by one stage and registers them.
// ---------------------------------------------------------------------------
module epr_cordic_cell import epr_pkg::*; #(
	parameter int STAGE = 0
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [TrigW-1:0] xi [3],
	input  logic signed [TrigW-1:0] yi [3],
	input  logic signed [ZW-1:0]    zi [3],
	output logic signed [TrigW-1:0] xo [3],
	output logic signed [TrigW-1:0] yo [3],
	output logic signed [ZW-1:0]    zo [3]
);

	localparam logic signed [ZW-1:0] Atan = atan_step(STAGE);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				if (!zi[k][ZW-1]) begin
					xo[k] <= xi[k] - (yi[k] >>> STAGE);
					yo[k] <= yi[k] + (xi[k] >>> STAGE);
					zo[k] <= zi[k] - Atan;
				end else begin
					xo[k] <= xi[k] + (yi[k] >>> STAGE);
					yo[k] <= yi[k] - (xi[k] >>> STAGE);
					zo[k] <= zi[k] + Atan;
				end
			end
		end
	end

endmodule

[src/epr_mulq.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// epr_mulq: rounded fixed-point product
// Computes a * t / 2^30, rounded half away from zero, over two stages.
// ---------------------------------------------------------------------------
module epr_mulq import epr_pkg::*; #(
	parameter int AW = 36
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [AW-1:0]    a,
	input  logic signed [TrigW-1:0] t,
	output logic signed [AW:0]      p
);

	localparam int PW = AW + TrigW;

	logic [AW-1:0] ua;
	logic [TrigW-1:0] ut;
	logic [PW-1:0] prod_s1;
	logic neg_s1;
	logic [PW-1:0] m;

	assign ua = a[AW-1] ? AW'(-a) : AW'(a);
	assign ut = t[TrigW-1] ? TrigW'(-t) : TrigW'(t);
	assign m = (prod_s1 + (PW'(1) << 29)) >> 30;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= PW'(ua) * PW'(ut);
			neg_s1 <= a[AW-1] ^ t[TrigW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p <= neg_s1 ? -$signed((AW+1)'(m)) : $signed((AW+1)'(m));
		end
	end

endmodule

[src/euler_point_rotation.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// euler_point_rotation: ZYX Euler rotation of a 3D point
// Phase reduction, a chain of CORDIC cells and three rotation stages.
// ---------------------------------------------------------------------------
// Accepts one word per cycle unless stalled and returns Rx*Ry*Rz*p, saturated
// Q16.16, through three phase reduction stages, the chain of CORDIC cells, the
// quadrant fold, three multiply-add rotations and the output register. The
// pipeline advances only when the output register is free or being taken.
module euler_point_rotation import epr_pkg::*; #(
	parameter int CORDIC_STAGES = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_word_t    in_word,
	output logic        out_valid,
	input  logic        out_stall,
	output out_word_t   out_word,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int Lat = CORDIC_STAGES + 11;
	localparam int W1 = CoordW + 4;

	logic deg_q;
	logic en;
	logic [Lat-1:0] vld_q;

	assign pready = 1'b1;
	assign prdata = {31'd0, deg_q};
	assign en = !out_valid || !out_stall;
	assign in_stall = !en;
	assign out_valid = vld_q[Lat-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deg_q <= 1'b0;
		end else if (psel && penable && pwrite && paddr == 2'(AddrCfgDeg)) begin
			deg_q <= pwdata[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[Lat-2:0], in_valid};
		end
	end

	// phase reduction: split product, phase sum, residual to radians
	logic [47:0] k;
	logic signed [CoordW-1:0] ang [3];
	logic signed [56:0] plo_s1 [3];
	logic signed [56:0] phi_s1 [3];
	logic [31:0] phase_s2 [3];
	logic [1:0] quad_s3 [3];
	logic signed [ZW-1:0] z_s3 [3];
	assign k = deg_q ? TurnPerDeg : TurnPerRad;
	assign ang[0] = in_word.angle_about_x;
	assign ang[1] = in_word.angle_about_y;
	assign ang[2] = in_word.angle_about_z;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				plo_s1[j] <= ang[j] * $signed({1'b0, k[23:0]});
				phi_s1[j] <= ang[j] * $signed({1'b0, k[47:24]});
				phase_s2[j] <= 32'((64'(plo_s1[j]) + (64'(phi_s1[j]) << 24)
					+ 64'h80000000) >> 32);
				quad_s3[j] <= phase_s2[j][31:30];
				z_s3[j] <= ZW'((64'(phase_s2[j][29:0]) * 64'(HalfPiQ30)
					+ 64'(1 << 29)) >> 30);
			end
		end
	end

	localparam int PB = CORDIC_STAGES + 3;

	// point delay line alongside the trig chain
	logic signed [CoordW-1:0] pt_q [PB+3][3];
	always_ff @(posedge clk) begin
		if (en) begin
			pt_q[0][0] <= in_word.point_x;
			pt_q[0][1] <= in_word.point_y;
			pt_q[0][2] <= in_word.point_z;
			for (int d = 1; d < PB + 3; d++) pt_q[d] <= pt_q[d-1];
		end
	end

	logic [1:0] quad_q [CORDIC_STAGES][3];
	always_ff @(posedge clk) begin
		if (en) begin
			quad_q[0] <= quad_s3;
			for (int d = 1; d < CORDIC_STAGES; d++) quad_q[d] <= quad_q[d-1];
		end
	end

	logic signed [TrigW-1:0] cx [CORDIC_STAGES+1][3];
	logic signed [TrigW-1:0] cy [CORDIC_STAGES+1][3];
	logic signed [ZW-1:0]    cz [CORDIC_STAGES+1][3];
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			cx[0][j] = InvGainQ30;
			cy[0][j] = '0;
			cz[0][j] = z_s3[j];
		end
	end

	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
		epr_cordic_cell #(.STAGE(g)) u_cell (
			.clk(clk), .en(en),
			.xi(cx[g]), .yi(cy[g]), .zi(cz[g]),
			.xo(cx[g+1]), .yo(cy[g+1]), .zo(cz[g+1])
		);
	end

	// quadrant fold into cos/sin, registered
	logic signed [TrigW-1:0] c_s3 [3];
	logic signed [TrigW-1:0] s_s3 [3];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				case (quad_q[CORDIC_STAGES-1][j])
					2'd0: begin
						c_s3[j] <= cx[CORDIC_STAGES][j];
						s_s3[j] <= cy[CORDIC_STAGES][j];
					end
					2'd1: begin
						c_s3[j] <= -cy[CORDIC_STAGES][j];
						s_s3[j] <= cx[CORDIC_STAGES][j];
					end
					2'd2: begin
						c_s3[j] <= -cx[CORDIC_STAGES][j];
						s_s3[j] <= -cy[CORDIC_STAGES][j];
					end
					default: begin
						c_s3[j] <= cy[CORDIC_STAGES][j];
						s_s3[j] <= -cx[CORDIC_STAGES][j];
					end
				endcase
			end
		end
	end

	// trig delay to line up with later rotations
	logic signed [TrigW-1:0] cxd [4], sxd [4], cyd [2], syd [2];
	always_ff @(posedge clk) begin
		if (en) begin
			cxd[0] <= c_s3[0]; sxd[0] <= s_s3[0];
			cyd[0] <= c_s3[1]; syd[0] <= s_s3[1];
			for (int d = 1; d < 4; d++) begin cxd[d] <= cxd[d-1]; sxd[d] <= sxd[d-1]; end
			cyd[1] <= cyd[0]; syd[1] <= syd[0];
		end
	end

	logic signed [W1-1:0] pxw, pyw, pzd;
	assign pxw = W1'(pt_q[PB][0]);
	assign pyw = W1'(pt_q[PB][1]);
	assign pzd = W1'(pt_q[PB+2][2]);

	// rotation about z
	logic signed [W1:0] m0, m1, m2, m3;
	epr_mulq #(.AW(W1)) u_m0 (.clk(clk), .en(en), .a(pxw), .t(c_s3[2]), .p(m0));
	epr_mulq #(.AW(W1)) u_m1 (.clk(clk), .en(en), .a(pyw), .t(s_s3[2]), .p(m1));
	epr_mulq #(.AW(W1)) u_m2 (.clk(clk), .en(en), .a(pxw), .t(s_s3[2]), .p(m2));
	epr_mulq #(.AW(W1)) u_m3 (.clk(clk), .en(en), .a(pyw), .t(c_s3[2]), .p(m3));
	logic signed [W1-1:0] x1, y1;
	assign x1 = W1'(m0 - m1);
	assign y1 = W1'(m2 + m3);

	// rotation about y
	logic signed [W1:0] n0, n1, n2, n3;
	epr_mulq #(.AW(W1)) u_n0 (.clk(clk), .en(en), .a(x1), .t(cyd[1]), .p(n0));
	epr_mulq #(.AW(W1)) u_n1 (.clk(clk), .en(en), .a(pzd), .t(syd[1]), .p(n1));
	epr_mulq #(.AW(W1)) u_n2 (.clk(clk), .en(en), .a(pzd), .t(cyd[1]), .p(n2));
	epr_mulq #(.AW(W1)) u_n3 (.clk(clk), .en(en), .a(x1), .t(syd[1]), .p(n3));
	logic signed [W1-1:0] y1d [2];
	always_ff @(posedge clk) begin
		if (en) begin
			y1d[0] <= y1;
			y1d[1] <= y1d[0];
		end
	end
	logic signed [W1:0] x2;
	logic signed [W1-1:0] z2;
	assign x2 = n0 + n1;
	assign z2 = W1'(n2 - n3);

	// rotation about x
	logic signed [W1:0] q0, q1, q2, q3;
	epr_mulq #(.AW(W1)) u_q0 (.clk(clk), .en(en), .a(y1d[1]), .t(cxd[3]), .p(q0));
	epr_mulq #(.AW(W1)) u_q1 (.clk(clk), .en(en), .a(z2), .t(sxd[3]), .p(q1));
	epr_mulq #(.AW(W1)) u_q2 (.clk(clk), .en(en), .a(y1d[1]), .t(sxd[3]), .p(q2));
	epr_mulq #(.AW(W1)) u_q3 (.clk(clk), .en(en), .a(z2), .t(cxd[3]), .p(q3));
	logic signed [W1:0] x2d [2];
	always_ff @(posedge clk) begin
		if (en) begin
			x2d[0] <= x2;
			x2d[1] <= x2d[0];
		end
	end

	function automatic logic signed [CoordW-1:0] sat(input logic signed [W1+1:0] v);
		if (v > $signed((W1+2)'({1'b0, {(CoordW-1){1'b1}}})))
			return {1'b0, {(CoordW-1){1'b1}}};
		else if (v < -$signed((W1+2)'({1'b1, {(CoordW-1){1'b0}}})))
			return {1'b1, {(CoordW-1){1'b0}}};
		else
			return CoordW'(v);
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			out_word.rotated_x <= sat((W1+2)'(x2d[1]));
			out_word.rotated_y <= sat((W1+2)'(q0) - (W1+2)'(q1));
			out_word.rotated_z <= sat((W1+2)'(q2) + (W1+2)'(q3));
		end
	end

endmodule
